### hw/rtl/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/u8u16_pkg.sv
// Types and constants of the UTF-8 to UTF-16 transcoder.
// Depends on nothing; used by every transcoder module.
package u8u16_pkg;

    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [30:0] BMP_MAX        = 31'h0000FFFD;
    localparam logic [30:0] PLANE_BASE     = 31'h00010000;
    localparam logic [30:0] CODE_POINT_MAX = 31'h0010FFFF;

    localparam int ACCUM_W   = 31;
    localparam int PENDING_W = 3;
    localparam int DATA_W    = 20;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_UNREP     = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_UNIT  = 2'd0,
        KIND_PAIR  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic {
        PH_FIRST  = 1'b0,
        PH_SECOND = 1'b1
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        status_t     status;
        logic        last_unit;
    } out_item_t;

    // Unit: data[15:0] is the code unit. Pair: data is the value minus 0x10000.
    typedef struct packed {
        kind_t             kind;
        status_t           status;
        logic [DATA_W-1:0] data;
    } entry_t;

endpackage

### hw/rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level: front decode, queue, back emit.
// Each result is written into the queue and then into the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair gives two output units.
// The queue absorbs pair expansion; input stalls only when the queue is full.
// Reset: asynchronous, active low; clears sequence state, queue and output valid.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8u16_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8u16_pkg::out_item_t out_item
);

    logic              push;
    logic              pop;
    logic              full;
    logic              head_valid;
    u8u16_pkg::entry_t push_entry;
    u8u16_pkg::entry_t head;

    assign in_ready = !full;

    u8u16_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push       (push),
        .push_entry (push_entry)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    u8u16_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### hw/rtl/u8u16_front.sv
// Front end: decodes UTF-8 bytes, tracks the partial sequence, classifies results.
// Depends on u8u16_pkg.
module u8u16_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  u8u16_pkg::in_item_t in_item,
    output logic                push,
    output u8u16_pkg::entry_t   push_entry
);

    logic [u8u16_pkg::PENDING_W-1:0] pending_reg;
    logic [u8u16_pkg::PENDING_W-1:0] pending_next;
    logic [u8u16_pkg::ACCUM_W-1:0]   accum_reg;
    logic [u8u16_pkg::ACCUM_W-1:0]   accum_next;
    logic                            accept;

    function automatic u8u16_pkg::entry_t finish_value(input logic [30:0] v);
        u8u16_pkg::entry_t e;
        e.kind   = u8u16_pkg::KIND_ERROR;
        e.status = u8u16_pkg::ST_UNREP;
        e.data   = '0;
        if (v <= u8u16_pkg::BMP_MAX)
        begin
            e.kind   = u8u16_pkg::KIND_UNIT;
            e.status = u8u16_pkg::ST_OK;
            e.data   = {4'd0, v[15:0]};
        end
        else if (v >= u8u16_pkg::PLANE_BASE && v <= u8u16_pkg::CODE_POINT_MAX)
        begin
            e.kind   = u8u16_pkg::KIND_PAIR;
            e.status = u8u16_pkg::ST_OK;
            e.data   = u8u16_pkg::DATA_W'(v - u8u16_pkg::PLANE_BASE);
        end
        return e;
    endfunction

    function automatic u8u16_pkg::entry_t error_entry(input u8u16_pkg::status_t st);
        u8u16_pkg::entry_t e;
        e.kind   = u8u16_pkg::KIND_ERROR;
        e.status = st;
        e.data   = '0;
        return e;
    endfunction

    assign accept = in_valid && in_ready;

    always_comb
    begin
        logic [u8u16_pkg::ACCUM_W-1:0]   acc;
        logic [u8u16_pkg::PENDING_W-1:0] pend;
        logic                            out_now;
        u8u16_pkg::entry_t               e;

        acc     = '0;
        pend    = '0;
        out_now = 1'b0;
        e       = error_entry(u8u16_pkg::ST_BAD_LEAD);

        if (pending_reg == '0)
        begin
            case (in_item.in_byte) inside
                [8'h01:8'h7F]:
                begin
                    out_now = 1'b1;
                    e = finish_value({23'd0, in_item.in_byte});
                end
                [8'hC0:8'hDF]:
                begin
                    pend = 3'd1;
                    acc  = {26'd0, in_item.in_byte[4:0]};
                end
                [8'hE0:8'hEF]:
                begin
                    pend = 3'd2;
                    acc  = {27'd0, in_item.in_byte[3:0]};
                end
                [8'hF0:8'hF7]:
                begin
                    pend = 3'd3;
                    acc  = {28'd0, in_item.in_byte[2:0]};
                end
                [8'hF8:8'hFB]:
                begin
                    pend = 3'd4;
                    acc  = {29'd0, in_item.in_byte[1:0]};
                end
                [8'hFC:8'hFD]:
                begin
                    pend = 3'd5;
                    acc  = {30'd0, in_item.in_byte[0]};
                end
                default:
                begin
                    out_now = 1'b1;
                    e = error_entry(u8u16_pkg::ST_BAD_LEAD);
                end
            endcase
            if (!out_now && in_item.end_of_stream)
            begin
                out_now = 1'b1;
                pend    = '0;
                acc     = '0;
                e       = error_entry(u8u16_pkg::ST_TRUNCATED);
            end
        end
        else if (in_item.in_byte[7:6] != 2'b10)
        begin
            out_now = 1'b1;
            e = error_entry(u8u16_pkg::ST_BAD_CONT);
        end
        else
        begin
            acc  = {accum_reg[24:0], in_item.in_byte[5:0]};
            pend = pending_reg - 3'd1;
            if (pend == '0)
            begin
                out_now = 1'b1;
                e = finish_value(acc);
                acc = '0;
            end
            else if (in_item.end_of_stream)
            begin
                out_now = 1'b1;
                pend    = '0;
                acc     = '0;
                e       = error_entry(u8u16_pkg::ST_TRUNCATED);
            end
        end

        pending_next = accept ? pend : pending_reg;
        accum_next   = accept ? acc : accum_reg;
        push         = accept && out_now;
        push_entry   = e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            accum_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

### hw/rtl/u8u16_queue.sv
// Short FIFO between the decode front end and the emit back end.
// Depends on u8u16_pkg.
module u8u16_queue #(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u8u16_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output u8u16_pkg::entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    u8u16_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/u8u16_back.sv
// Back end: expands queued entries into UTF-16 units or error results.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  u8u16_pkg::entry_t    head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8u16_pkg::out_item_t out_item
);

    u8u16_pkg::phase_t    phase_reg;
    u8u16_pkg::phase_t    phase_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    u8u16_pkg::out_item_t out_item_reg;
    u8u16_pkg::out_item_t result;
    logic                 load;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (load && head.kind == u8u16_pkg::KIND_PAIR)
        begin
            case (phase_reg)
                u8u16_pkg::PH_FIRST:  phase_next = u8u16_pkg::PH_SECOND;
                u8u16_pkg::PH_SECOND: phase_next = u8u16_pkg::PH_FIRST;
                default:              phase_next = u8u16_pkg::PH_FIRST;
            endcase
        end
    end

    always_comb
    begin
        pop = load && (head.kind != u8u16_pkg::KIND_PAIR
                       || phase_reg == u8u16_pkg::PH_SECOND);
        result.code_unit = '0;
        result.status    = head.status;
        result.last_unit = 1'b1;
        case (head.kind)
            u8u16_pkg::KIND_UNIT:
            begin
                result.code_unit = head.data[15:0];
                result.status    = u8u16_pkg::ST_OK;
            end
            u8u16_pkg::KIND_PAIR:
            begin
                result.status = u8u16_pkg::ST_OK;
                if (phase_reg == u8u16_pkg::PH_FIRST)
                begin
                    result.code_unit = u8u16_pkg::SURR_HIGH_BASE + {6'd0, head.data[19:10]};
                    result.last_unit = 1'b0;
                end
                else
                begin
                    result.code_unit = u8u16_pkg::SURR_LOW_BASE + {6'd0, head.data[9:0]};
                end
            end
            default:
            begin
                result.code_unit = '0;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= u8u16_pkg::PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_second_half_queued, clk, rst_n, phase_reg == u8u16_pkg::PH_SECOND, head_valid && head.kind == u8u16_pkg::KIND_PAIR)
    `ASSERT_IMPLIES(a_pop_has_entry, clk, rst_n, pop, head_valid)
    `ASSERT_IMPLIES(a_high_half_form, clk, rst_n, out_valid_reg && !out_item_reg.last_unit, out_item_reg.status == u8u16_pkg::ST_OK && out_item_reg.code_unit[15:10] == 6'b110110)
    `ASSERT_IMPLIES(a_error_form, clk, rst_n, out_valid_reg && out_item_reg.status != u8u16_pkg::ST_OK, out_item_reg.code_unit == 16'd0 && out_item_reg.last_unit)
    `ASSERT_NEXT(a_high_then_pending_low, clk, rst_n, load && phase_reg == u8u16_pkg::PH_FIRST && head.kind == u8u16_pkg::KIND_PAIR, phase_reg == u8u16_pkg::PH_SECOND)

endmodule

### tb/utf8_to_utf16_transcoder_test.sv
// Self-checking testbench for utf8_to_utf16_transcoder: directed and random UTF-8 byte
// streams with bursty input and stalled output, checked against a built-in transcoder.
// Depends on u8u16_pkg and the utf8_to_utf16_transcoder RTL.
module utf8_to_utf16_transcoder_test;

    localparam int RANDOM_BYTES = 1650;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 50;

    localparam int DIRECTED_LEN = 30;
    // {end_of_stream, in_byte}
    localparam logic [8:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
        9'h000, 9'h080, 9'h1FF,
        9'h0C0, 9'h080,
        9'h0ED, 9'h0A0, 9'h080,
        9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
        9'h0F8, 9'h088, 9'h080, 9'h080, 9'h080,
        9'h0FC, 9'h080, 9'h080, 9'h080, 9'h080, 9'h081,
        9'h0E2, 9'h000,
        9'h0E2, 9'h182
    };

    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_BAD_CONT,
        SHAPE_CUT_SHORT
    } seq_shape_t;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    u8u16_pkg::in_item_t  in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    u8u16_pkg::out_item_t out_item;

    u8u16_pkg::in_item_t  stimulus_bytes [$];
    u8u16_pkg::out_item_t expected_units [$];
    logic [2:0]           cont_left = '0;
    logic [30:0]          cp_accum  = '0;

    int          total_bytes    = 0;
    int          bytes_taken    = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;

    int          burst_left = 0;
    int          gap_left   = 0;
    rx_mode_t    rx_mode    = RX_OPEN;
    int          rx_left    = 0;

    utf8_to_utf16_transcoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, want, got);
        end
    endtask

    function automatic void push_unit(input logic [15:0] unit,
                                      input u8u16_pkg::status_t st,
                                      input logic last);
        u8u16_pkg::out_item_t o;
        o.code_unit = unit;
        o.status    = st;
        o.last_unit = last;
        expected_units = {expected_units, o};
    endfunction

    function automatic void flag_error(input u8u16_pkg::status_t st);
        cont_left = '0;
        cp_accum  = '0;
        push_unit(16'h0000, st, 1'b1);
    endfunction

    function automatic void complete_point(input logic [30:0] v);
        logic [30:0] d;
        cont_left = '0;
        cp_accum  = '0;
        if (v <= u8u16_pkg::BMP_MAX)
        begin
            push_unit(v[15:0], u8u16_pkg::ST_OK, 1'b1);
        end
        else if (v >= u8u16_pkg::PLANE_BASE && v <= u8u16_pkg::CODE_POINT_MAX)
        begin
            d = v - u8u16_pkg::PLANE_BASE;
            push_unit(u8u16_pkg::SURR_HIGH_BASE + {6'd0, d[19:10]}, u8u16_pkg::ST_OK, 1'b0);
            push_unit(u8u16_pkg::SURR_LOW_BASE + {6'd0, d[9:0]}, u8u16_pkg::ST_OK, 1'b1);
        end
        else
        begin
            push_unit(16'h0000, u8u16_pkg::ST_UNREP, 1'b1);
        end
    endfunction

    function automatic void transcode_byte(input u8u16_pkg::in_item_t it);
        logic [7:0] b;
        b = it.in_byte;
        if (cont_left == 3'd0)
        begin
            if (b == 8'h00 || b[7:6] == 2'b10 || b >= 8'hFE)
            begin
                flag_error(u8u16_pkg::ST_BAD_LEAD);
                return;
            end
            if (b < 8'h80)
            begin
                complete_point({23'd0, b});
                return;
            end
            if (b < 8'hE0)
            begin
                cont_left = 3'd1;
                cp_accum  = 31'(b - 8'hC0);
            end
            else if (b < 8'hF0)
            begin
                cont_left = 3'd2;
                cp_accum  = 31'(b - 8'hE0);
            end
            else if (b < 8'hF8)
            begin
                cont_left = 3'd3;
                cp_accum  = 31'(b - 8'hF0);
            end
            else if (b < 8'hFC)
            begin
                cont_left = 3'd4;
                cp_accum  = 31'(b - 8'hF8);
            end
            else
            begin
                cont_left = 3'd5;
                cp_accum  = 31'(b - 8'hFC);
            end
            if (it.end_of_stream)
                flag_error(u8u16_pkg::ST_TRUNCATED);
        end
        else if (b[7:6] != 2'b10)
        begin
            flag_error(u8u16_pkg::ST_BAD_CONT);
        end
        else
        begin
            cp_accum  = {cp_accum[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0)
                complete_point(cp_accum);
            else if (it.end_of_stream)
                flag_error(u8u16_pkg::ST_TRUNCATED);
        end
    endfunction

    task automatic check_result(input u8u16_pkg::out_item_t got);
        u8u16_pkg::out_item_t want;
        if (expected_units.size() == 0)
        begin
            report_mismatch("unexpected transaction, code_unit", 32'h0,
                            32'(got.code_unit));
            return;
        end
        want = expected_units.pop_front();
        if (got.code_unit !== want.code_unit)
            report_mismatch("code_unit", 32'(want.code_unit), 32'(got.code_unit));
        if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.last_unit !== want.last_unit)
            report_mismatch("last_unit", 32'(want.last_unit), 32'(got.last_unit));
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eos);
        u8u16_pkg::in_item_t it;
        it.in_byte       = b;
        it.end_of_stream = eos;
        stimulus_bytes = {stimulus_bytes, it};
    endtask

    function automatic logic [30:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return 31'($urandom_range(0, 32'h10FFFF));
            4:          return 31'($urandom);
            5:
            begin
                case ($urandom_range(0, 9))
                    0: return 31'h0000FFFD;
                    1: return 31'h0000FFFE;
                    2: return 31'h0000FFFF;
                    3: return 31'h00010000;
                    4: return 31'h0010FFFF;
                    5: return 31'h00110000;
                    6: return 31'h00000000;
                    7: return 31'h7FFFFFFF;
                    8: return 31'h0000D7FF;
                    default: return 31'h0000E000;
                endcase
            end
            6:          return 31'($urandom_range(32'hD800, 32'hDFFF));
            7:          return 31'($urandom_range(0, 32'h7FF));
            default:    return 31'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
    endfunction

    task automatic add_sequence(input seq_shape_t shape);
        int          r;
        int          n;
        int          cut;
        int          bits;
        int          p;
        logic [31:0] mask;
        logic [30:0] v;
        logic [30:0] top;
        logic [7:0]  b;
        logic        eos;
        r = $urandom_range(0, 99);
        n = (r < 30) ? 1 : (r < 48) ? 2 : (r < 66) ? 3 : (r < 88) ? 4 : (r < 94) ? 5 : 6;
        if (shape != SHAPE_CLEAN && n == 1)
            n = $urandom_range(2, 6);
        bits = (n == 1) ? 7 : 5 * n + 1;
        mask = (32'h1 << bits) - 32'h1;
        v    = pick_value() & mask[30:0];
        if (n == 1)
        begin
            add_byte(v[7:0], $urandom_range(0, 15) == 0);
            return;
        end
        cut = (shape == SHAPE_BAD_CONT)  ? $urandom_range(1, n - 1) :
              (shape == SHAPE_CUT_SHORT) ? $urandom_range(0, n - 2) : n;
        top = v >> (6 * (n - 1));
        b   = 8'(8'hFF << (8 - n)) | top[7:0];
        add_byte(b, shape == SHAPE_CUT_SHORT && cut == 0);
        if (shape == SHAPE_CUT_SHORT && cut == 0)
            return;
        for (p = 1; p < n; p++)
        begin
            b = {2'b10, v[6 * (n - 1 - p) +: 6]};
            if (shape == SHAPE_BAD_CONT && p == cut)
            begin
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                add_byte(b, $urandom_range(0, 7) == 0);
                return;
            end
            eos = (shape == SHAPE_CUT_SHORT && p == cut) ||
                  (shape == SHAPE_CLEAN && p == n - 1 && $urandom_range(0, 15) == 0);
            add_byte(b, eos);
            if (shape == SHAPE_CUT_SHORT && p == cut)
                return;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r < 8)
            return $urandom_range(1, 3);
        if (r < 9)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Driver: hold each transaction until accepted, pause between bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (stimulus_bytes.size() > 0)
            begin
                in_item  <= stimulus_bytes.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                end
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = pick_gap();
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a random mode that is re-picked when its random span runs out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   = RX_OPEN;
            rx_left   = 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            else
            begin
                rx_left = rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ((rx_left % 8) >= 5);
            endcase
        end
    end

    // Monitor: predict on each accepted byte, then check the output transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                transcode_byte(in_item);
                bytes_taken++;
            end
            if (out_valid && out_ready)
                check_result(out_item);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int r;
        foreach (DIRECTED_BYTES[i])
            add_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        while (stimulus_bytes.size() < DIRECTED_LEN + RANDOM_BYTES)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                add_byte(8'($urandom), $urandom_range(0, 7) == 0);
            else if (r == 1)
                add_sequence(($urandom_range(0, 1) == 0) ? SHAPE_BAD_CONT : SHAPE_CUT_SHORT);
            else
                add_sequence(SHAPE_CLEAN);
        end
        total_bytes = stimulus_bytes.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_taken < total_bytes || expected_units.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
